[rtl/matrix_3x3_inverse_top_assert.svh]
// Assertion macros for the 3x3 matrix inverse block.
// Included by matrix_3x3_inverse_top; no other dependencies.
`ifndef MATRIX_3X3_INVERSE_TOP_ASSERT_SVH
`define MATRIX_3X3_INVERSE_TOP_ASSERT_SVH

// same-cycle implication
`define MI3_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("matrix inverse check failed");

// next-cycle implication
`define MI3_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("matrix inverse check failed");

`endif

[rtl/mi3_pkg.sv]
// Shared constants, lane operand tables and types for the 3x3 matrix inverse.
// No dependencies.
`default_nettype none
package mi3_pkg;

    localparam int ELEMENT_BITS_DEF  = 16;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int DIM       = 3;
    localparam int NELEM     = DIM * DIM;
    localparam int IN_W      = 16;
    localparam int OUT_W     = 49;
    localparam int IDX_W     = 2;
    localparam int S_TDATA_W = NELEM * IN_W;
    localparam int M_FIELD_W = 2 * IDX_W + 2 * OUT_W;
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DIM - 1);

    // minor(k) = e[A]*e[B] - e[C]*e[D], flat row-major element indexes
    localparam int LANE_A [NELEM] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
    localparam int LANE_B [NELEM] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
    localparam int LANE_C [NELEM] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
    localparam int LANE_D [NELEM] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

    typedef struct packed {
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic             last;
        logic             singular;
        logic [OUT_W-1:0] det;
    } mi3_meta_t;

endpackage
`default_nettype wire

[rtl/matrix_3x3_inverse_top.sv]
// The serializer issues the nine elements of each matrix into the single divider pipeline, one
// element per cycle while the output is not stalled; the front end may work on the next matrix
// meanwhile. A singular matrix issues a single element only.
// Reset: aresetn synchronous, active low; clears all valid bits and state, no data.
`default_nettype none
`include "matrix_3x3_inverse_top_assert.svh"
module matrix_3x3_inverse_top
    import mi3_pkg::*;
#(
    parameter int ELEMENT_BITS  = ELEMENT_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // a00, a01, a02, a10, a11, a12, a20, a21, a22 (16 bits each)
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // row_index, col_index, inverse_value, determinant, zero pad
    output logic [M_TDATA_W-1:0] m_tdata,
    // singular
    output logic                 m_tuser,
    output logic                 m_tlast
);

    localparam int AW  = 2 * ELEMENT_BITS + 1;
    localparam int DW  = 3 * ELEMENT_BITS + 1;
    localparam int XDW = (DW > OUT_W) ? DW : OUT_W;

    // input holding register lets the slave side accept one matrix while the front end is busy
    logic                 buf_valid_reg;
    logic [S_TDATA_W-1:0] buf_data_reg;
    logic                 front_in_take;
    logic                 front_valid;
    logic [NELEM-1:0][AW-1:0] front_adj;
    logic [DW-1:0]        front_det;
    logic                 front_take;

    assign s_tready = !buf_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buf_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            buf_valid_reg <= 1'b1;
        end else if (front_in_take) begin
            buf_valid_reg <= 1'b0;
        end
        if (s_tvalid && s_tready) begin
            buf_data_reg <= s_tdata;
        end
    end

    mi3_front #(
        .ELEMENT_BITS(ELEMENT_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (buf_valid_reg),
        .in_data   (buf_data_reg),
        .in_take   (front_in_take),
        .out_take  (front_take),
        .out_valid (front_valid),
        .adj       (front_adj),
        .det       (front_det)
    );

    // serializer: one adjugate element per advancing cycle
    logic                     adv;
    logic                     ser_valid_reg;
    logic [NELEM-1:0][AW-1:0] ser_adj_reg;
    logic signed [DW-1:0]     ser_det_reg;
    logic                     ser_sing_reg;
    logic [IDX_W-1:0]         ser_row_reg;
    logic [IDX_W-1:0]         ser_col_reg;
    logic                     issue;
    logic                     issue_last;
    logic signed [XDW-1:0]    det_x;
    mi3_meta_t                div_meta_in;
    logic                     div_valid;
    logic [OUT_W-1:0]         div_value;
    mi3_meta_t                div_meta;

    assign adv        = !div_valid || m_tready;
    assign issue      = ser_valid_reg && adv;
    assign issue_last = ser_sing_reg || ((ser_row_reg == IDX_LAST) && (ser_col_reg == IDX_LAST));
    assign front_take = front_valid && (!ser_valid_reg || (issue && issue_last));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ser_valid_reg <= 1'b0;
            ser_row_reg   <= '0;
            ser_col_reg   <= '0;
        end else if (front_take) begin
            ser_valid_reg <= 1'b1;
            ser_row_reg   <= '0;
            ser_col_reg   <= '0;
        end else if (issue) begin
            if (issue_last) begin
                ser_valid_reg <= 1'b0;
            end
            if (ser_col_reg == IDX_LAST) begin
                ser_col_reg <= '0;
                ser_row_reg <= ser_row_reg + IDX_W'(1);
            end else begin
                ser_col_reg <= ser_col_reg + IDX_W'(1);
            end
        end
        if (front_take) begin
            ser_adj_reg  <= front_adj;
            ser_det_reg  <= signed'(front_det);
            ser_sing_reg <= (front_det == '0);
        end else if (issue) begin
            for (int i = 0; i < NELEM - 1; i++) begin
                ser_adj_reg[i] <= ser_adj_reg[i+1];
            end
        end
    end

    assign det_x = XDW'(ser_det_reg);

    always_comb begin
        div_meta_in.row      = ser_row_reg;
        div_meta_in.col      = ser_col_reg;
        div_meta_in.last     = issue_last;
        div_meta_in.singular = ser_sing_reg;
        div_meta_in.det      = det_x[OUT_W-1:0];
    end

    mi3_divider #(
        .ELEMENT_BITS  (ELEMENT_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (ser_valid_reg),
        .num       (signed'(ser_adj_reg[0])),
        .den       (ser_det_reg),
        .in_meta   (div_meta_in),
        .out_valid (div_valid),
        .out_value (div_value),
        .out_meta  (div_meta)
    );

    assign m_tvalid = div_valid;
    assign m_tdata  = M_TDATA_W'({div_meta.det, div_value, div_meta.col, div_meta.row});
    assign m_tuser  = div_meta.singular;
    assign m_tlast  = div_meta.last;

    `MI3_ASSERT_NOW(a_singular_alone, aclk, aresetn, m_tvalid && m_tuser, m_tlast && (m_tdata == '0))
    `MI3_ASSERT_NEXT(a_ser_hold, aclk, aresetn, ser_valid_reg && !adv, ser_valid_reg && $stable(ser_row_reg) && $stable(ser_col_reg))
    `MI3_ASSERT_NOW(a_ser_index, aclk, aresetn, ser_valid_reg, (ser_row_reg != 2'd3) && (ser_col_reg != 2'd3))

endmodule
`default_nettype wire

[rtl/mi3_cofactor_lane.sv]
// One cofactor lane: signed 2x2 minor p*q - r*s over two registered steps.
// Depends on mi3_pkg.
`default_nettype none
module mi3_cofactor_lane
    import mi3_pkg::*;
#(
    parameter int ELEMENT_BITS = ELEMENT_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          mul_en,
    input  logic                          sub_en,
    input  logic signed [ELEMENT_BITS-1:0] p,
    input  logic signed [ELEMENT_BITS-1:0] q,
    input  logic signed [ELEMENT_BITS-1:0] r,
    input  logic signed [ELEMENT_BITS-1:0] s,
    output logic signed [2*ELEMENT_BITS:0] minor
);

    localparam int PW = 2 * ELEMENT_BITS;
    localparam int AW = PW + 1;

    logic signed [PW-1:0] pq_reg;
    logic signed [PW-1:0] rs_reg;
    logic signed [AW-1:0] minor_reg;

    always_ff @(posedge aclk) begin
        if (mul_en) begin
            pq_reg <= PW'(p) * PW'(q);
            rs_reg <= PW'(r) * PW'(s);
        end
        if (sub_en) begin
            minor_reg <= AW'(pq_reg) - AW'(rs_reg);
        end
    end

    assign minor = minor_reg;

endmodule
`default_nettype wire

[rtl/mi3_front.sv]
// Front end: nine cofactor lanes build the adjugate, a merge step forms the determinant.
// Depends on mi3_pkg and mi3_cofactor_lane.
`default_nettype none
module mi3_front
    import mi3_pkg::*;
#(
    parameter int ELEMENT_BITS = ELEMENT_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 in_valid,
    input  logic [S_TDATA_W-1:0]                 in_data,
    output logic                                 in_take,
    input  logic                                 out_take,
    output logic                                 out_valid,
    output logic [NELEM-1:0][2*ELEMENT_BITS:0]   adj,
    output logic [3*ELEMENT_BITS:0]              det
);

    localparam int AW = 2 * ELEMENT_BITS + 1;
    localparam int DW = 3 * ELEMENT_BITS + 1;
    localparam int PW = ELEMENT_BITS + AW;
    localparam int SW = PW + 2;
    localparam int XW = (ELEMENT_BITS > IN_W) ? ELEMENT_BITS : IN_W;

    typedef enum logic [2:0] {F_IDLE, F_MUL, F_ADJ, F_DMUL, F_DSUM, F_DONE} front_state_t;

    front_state_t                  state_reg;
    logic signed [ELEMENT_BITS-1:0] e_in  [NELEM];
    logic signed [ELEMENT_BITS-1:0] e_reg [NELEM];
    logic signed [AW-1:0]           minor [NELEM];
    logic signed [PW-1:0]           dp_reg [DIM];
    logic signed [DW-1:0]           det_reg;
    logic signed [SW-1:0]           det_sum;

    // only the low ELEMENT_BITS of each field count, sign taken from the top one
    always_comb begin
        logic [XW-1:0] raw;
        for (int i = 0; i < NELEM; i++) begin
            raw     = XW'(in_data[i*IN_W +: IN_W]);
            e_in[i] = signed'(raw[ELEMENT_BITS-1:0]);
        end
    end

    assign in_take = in_valid && (state_reg == F_IDLE);

    for (genvar k = 0; k < NELEM; k++) begin : g_lane
        mi3_cofactor_lane #(
            .ELEMENT_BITS(ELEMENT_BITS)
        ) u_lane (
            .aclk   (aclk),
            .mul_en (state_reg == F_MUL),
            .sub_en (state_reg == F_ADJ),
            .p      (e_reg[LANE_A[k]]),
            .q      (e_reg[LANE_B[k]]),
            .r      (e_reg[LANE_C[k]]),
            .s      (e_reg[LANE_D[k]]),
            .minor  (minor[k])
        );
        assign adj[k] = minor[k];
    end

    // expansion along the first row: e0j * adj[j][0]
    assign det_sum = SW'(dp_reg[0]) + SW'(dp_reg[1]) + SW'(dp_reg[2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            case (state_reg)
                F_IDLE: begin
                    if (in_valid) state_reg <= F_MUL;
                end
                F_MUL:  state_reg <= F_ADJ;
                F_ADJ:  state_reg <= F_DMUL;
                F_DMUL: state_reg <= F_DSUM;
                F_DSUM: state_reg <= F_DONE;
                F_DONE: begin
                    if (out_take) state_reg <= F_IDLE;
                end
                default: state_reg <= F_IDLE;
            endcase
        end
        if (in_take) begin
            e_reg <= e_in;
        end
        if (state_reg == F_DMUL) begin
            for (int j = 0; j < DIM; j++) begin
                dp_reg[j] <= PW'(e_reg[j]) * PW'(minor[j*DIM]);
            end
        end
        if (state_reg == F_DSUM) begin
            det_reg <= DW'(det_sum);
        end
    end

    assign out_valid = (state_reg == F_DONE);
    assign det       = det_reg;

endmodule
`default_nettype wire

[rtl/mi3_divider.sv]
// Pipelined restoring divider: one quotient bit per stage, then round and saturate.
// Depends on mi3_pkg.
`default_nettype none
module mi3_divider
    import mi3_pkg::*;
#(
    parameter int ELEMENT_BITS  = ELEMENT_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           en,
    input  logic                           in_valid,
    input  logic signed [2*ELEMENT_BITS:0] num,
    input  logic signed [3*ELEMENT_BITS:0] den,
    input  mi3_meta_t                      in_meta,
    output logic                           out_valid,
    output logic [OUT_W-1:0]               out_value,
    output mi3_meta_t                      out_meta
);

    localparam int AW = 2 * ELEMENT_BITS + 1;
    localparam int DW = 3 * ELEMENT_BITS + 1;
    localparam int UW = 2 * ELEMENT_BITS;
    localparam int UD = 3 * ELEMENT_BITS;
    localparam int RW = UD + 1;
    localparam int NB = UW + FRACTION_BITS + 1;
    localparam int CW = (NB > OUT_W - 1) ? NB : OUT_W - 1;
    localparam logic [CW-1:0] LIM = CW'({(OUT_W - 1){1'b1}});

    logic            st_v    [NB+1];
    logic [RW-1:0]   st_r    [NB+1];
    logic [NB-1:0]   st_n    [NB+1];
    logic [NB-1:0]   st_q    [NB+1];
    logic [UD-1:0]   st_d    [NB+1];
    logic            st_neg  [NB+1];
    logic            st_zero [NB+1];
    mi3_meta_t       st_meta [NB+1];

    logic [AW-1:0]   num_abs;
    logic [DW-1:0]   den_abs;

    assign num_abs = (num < 0) ? AW'(-num) : AW'(num);
    assign den_abs = (den < 0) ? DW'(-den) : DW'(den);

    // stage 0: magnitudes, dividend pre-shifted by FRACTION_BITS+1 for the round bit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_v[0] <= 1'b0;
        end else if (en) begin
            st_v[0] <= in_valid;
        end
        if (en) begin
            st_r[0]    <= '0;
            st_n[0]    <= {num_abs[UW-1:0], {(FRACTION_BITS + 1){1'b0}}};
            st_q[0]    <= '0;
            st_d[0]    <= den_abs[UD-1:0];
            st_neg[0]  <= num[AW-1] ^ den[DW-1];
            st_zero[0] <= (num == 0) || (den == 0);
            st_meta[0] <= in_meta;
        end
    end

    for (genvar k = 0; k < NB; k++) begin : g_stage
        logic [RW-1:0] r_sh;
        logic          ge;

        assign r_sh = {st_r[k][RW-2:0], st_n[k][NB-1]};
        assign ge   = (r_sh >= RW'(st_d[k]));

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                st_v[k+1] <= 1'b0;
            end else if (en) begin
                st_v[k+1] <= st_v[k];
            end
            if (en) begin
                st_r[k+1]    <= ge ? (r_sh - RW'(st_d[k])) : r_sh;
                st_n[k+1]    <= st_n[k] << 1;
                st_q[k+1]    <= {st_q[k][NB-2:0], ge};
                st_d[k+1]    <= st_d[k];
                st_neg[k+1]  <= st_neg[k];
                st_zero[k+1] <= st_zero[k];
                st_meta[k+1] <= st_meta[k];
            end
        end
    end

    // half up on the magnitude gives ties away from zero after the sign
    logic [NB:0]        q_inc;
    logic [CW-1:0]      q_rnd;
    logic [CW-1:0]      q_sat;
    logic [OUT_W-1:0]   q_mag;
    logic [OUT_W-1:0]   q_val;

    assign q_inc = {1'b0, st_q[NB]} + (NB + 1)'(1);
    assign q_rnd = CW'(q_inc[NB:1]);
    assign q_sat = (q_rnd > LIM) ? LIM : q_rnd;
    assign q_mag = {1'b0, q_sat[OUT_W-2:0]};
    assign q_val = st_zero[NB] ? '0 : (st_neg[NB] ? (~q_mag + OUT_W'(1)) : q_mag);

    logic            out_v_reg;
    logic [OUT_W-1:0] out_value_reg;
    mi3_meta_t       out_meta_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (en) begin
            out_v_reg <= st_v[NB];
        end
        if (en) begin
            out_value_reg <= q_val;
            out_meta_reg  <= st_meta[NB];
        end
    end

    assign out_valid = out_v_reg;
    assign out_value = out_value_reg;
    assign out_meta  = out_meta_reg;

endmodule
`default_nettype wire
